FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, switched off while reset is applied
`define SRL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("srl assertion failed");

// checked property that also holds through reset
`define SRL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("srl assertion failed");

`endif

FILE: rtl/core/srl_pkg.sv
package srl_pkg;

    // move phases
    localparam int PhaseWidth = 2;
    localparam logic [PhaseWidth-1:0] PhIdle   = 2'd0;
    localparam logic [PhaseWidth-1:0] PhSettle = 2'd1;
    localparam logic [PhaseWidth-1:0] PhLow    = 2'd2;
    localparam logic [PhaseWidth-1:0] PhHigh   = 2'd3;

    // command codes
    localparam logic CmdTick  = 1'b0;
    localparam logic CmdStart = 1'b1;

    // status codes
    localparam logic StatAlreadyThere = 1'b0;
    localparam logic StatArrived      = 1'b1;

    // register map
    localparam int AddrWidth = 5;
    localparam int DataWidth = 32;
    localparam logic [2:0] RegStartHalfPeriod = 3'd0;
    localparam logic [2:0] RegMinHalfPeriod   = 3'd1;
    localparam logic [2:0] RegRampEvery       = 3'd2;
    localparam logic [2:0] RegArriveSteps     = 3'd3;
    localparam logic [2:0] RegSettleTicks     = 3'd4;

    // register reset values
    localparam logic [15:0] RstStartHalfPeriod = 16'd1000;
    localparam logic [15:0] RstMinHalfPeriod   = 16'd250;
    localparam logic [7:0]  RstRampEvery       = 8'd2;
    localparam logic [15:0] RstArriveSteps     = 16'd600;
    localparam logic [15:0] RstSettleTicks     = 16'd10000;

    typedef struct packed {
        logic [15:0] start_half_period;
        logic [15:0] min_half_period;
        logic [7:0]  ramp_every;
        logic [15:0] arrive_steps;
        logic [15:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic command;
        logic direction;
        logic back_limit;
        logic out_limit;
    } item_t;

    typedef struct packed {
        logic step_pin;
        logic dir_pin;
        logic enable_pin;
        logic busy_res;
        logic status_valid;
        logic status;
    } res_t;

endpackage

FILE: rtl/core/srl_cfg.sv
module srl_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srl_pkg::AddrWidth-1:0]      paddr,
    input  logic [srl_pkg::DataWidth-1:0]      pwdata,
    output logic [srl_pkg::DataWidth-1:0]      prdata,
    output logic                               pready,
    output srl_pkg::cfg_t                      cfg
);

    srl_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[srl_pkg::AddrWidth-1:2];
    assign cfg     = cfg_reg;

    // register writes, out-of-range addresses are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_half_period <= srl_pkg::RstStartHalfPeriod;
            cfg_reg.min_half_period   <= srl_pkg::RstMinHalfPeriod;
            cfg_reg.ramp_every        <= srl_pkg::RstRampEvery;
            cfg_reg.arrive_steps      <= srl_pkg::RstArriveSteps;
            cfg_reg.settle_ticks      <= srl_pkg::RstSettleTicks;
        end else if (wr_en) begin
            case (reg_idx)
                srl_pkg::RegStartHalfPeriod: cfg_reg.start_half_period <= pwdata[15:0];
                srl_pkg::RegMinHalfPeriod:   cfg_reg.min_half_period   <= pwdata[15:0];
                srl_pkg::RegRampEvery:       cfg_reg.ramp_every        <= pwdata[7:0];
                srl_pkg::RegArriveSteps:     cfg_reg.arrive_steps      <= pwdata[15:0];
                srl_pkg::RegSettleTicks:     cfg_reg.settle_ticks      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (reg_idx)
            srl_pkg::RegStartHalfPeriod: prdata = 32'(cfg_reg.start_half_period);
            srl_pkg::RegMinHalfPeriod:   prdata = 32'(cfg_reg.min_half_period);
            srl_pkg::RegRampEvery:       prdata = 32'(cfg_reg.ramp_every);
            srl_pkg::RegArriveSteps:     prdata = 32'(cfg_reg.arrive_steps);
            srl_pkg::RegSettleTicks:     prdata = 32'(cfg_reg.settle_ticks);
            default:                     prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/srl_core.sv
`include "assert_macros.svh"

module srl_core #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  srl_pkg::item_t item,
    input  srl_pkg::cfg_t  cfg,
    output srl_pkg::res_t  res
);

    localparam int CmpWidth = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    logic [srl_pkg::PhaseWidth-1:0] phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]         tick_timer_reg, tick_timer_next;
    logic [TIMER_WIDTH-1:0]         half_period_reg, half_period_next;
    logic [15:0]                    hit_count_reg, hit_count_next;
    logic [7:0]                     ramp_count_reg, ramp_count_next;
    logic                           move_dir_reg, move_dir_next;
    logic                           enable_reg, enable_next;

    logic                   wait_done;
    logic [TIMER_WIDTH-1:0] timer_dec;
    logic                   limit;
    logic [CmpWidth-1:0]    settle_ext, start_ext, min_ext, half_ext;
    logic [8:0]             ramp_sum;
    logic                   sval, stat;

    // timer countdown, values zero and one both expire on the first tick
    assign wait_done = (tick_timer_reg <= TIMER_WIDTH'(1));
    assign timer_dec = wait_done ? '0 : tick_timer_reg - TIMER_WIDTH'(1);
    assign limit     = move_dir_reg ? item.out_limit : item.back_limit;

    // register values brought to a common compare width
    assign settle_ext = CmpWidth'(cfg.settle_ticks);
    assign start_ext  = CmpWidth'(cfg.start_half_period);
    assign min_ext    = CmpWidth'(cfg.min_half_period);
    assign half_ext   = CmpWidth'(half_period_reg);
    assign ramp_sum   = {1'b0, ramp_count_reg} + 9'd1;

    // next-state logic for one item
    always_comb begin
        phase_next       = phase_reg;
        tick_timer_next  = tick_timer_reg;
        half_period_next = half_period_reg;
        hit_count_next   = hit_count_reg;
        ramp_count_next  = ramp_count_reg;
        move_dir_next    = move_dir_reg;
        enable_next      = enable_reg;
        sval             = 1'b0;
        stat             = srl_pkg::StatAlreadyThere;

        if (item.command == srl_pkg::CmdStart) begin
            // start is ignored while a move runs
            if (phase_reg == srl_pkg::PhIdle) begin
                enable_next      = 1'b1;
                move_dir_next    = item.direction;
                tick_timer_next  = settle_ext[TIMER_WIDTH-1:0];
                half_period_next = start_ext[TIMER_WIDTH-1:0];
                hit_count_next   = '0;
                ramp_count_next  = '0;
                phase_next       = srl_pkg::PhSettle;
            end
        end else begin
            case (phase_reg)
                srl_pkg::PhSettle: begin
                    tick_timer_next = timer_dec;
                    if (wait_done) begin
                        if (limit) begin
                            phase_next = srl_pkg::PhIdle;
                            sval       = 1'b1;
                        end else if (cfg.arrive_steps == 16'd0) begin
                            enable_next = 1'b0;
                            phase_next  = srl_pkg::PhIdle;
                            sval        = 1'b1;
                            stat        = srl_pkg::StatArrived;
                        end else begin
                            phase_next      = srl_pkg::PhLow;
                            tick_timer_next = half_period_reg;
                        end
                    end
                end
                srl_pkg::PhLow: begin
                    tick_timer_next = timer_dec;
                    if (wait_done) begin
                        phase_next      = srl_pkg::PhHigh;
                        tick_timer_next = half_period_reg;
                    end
                end
                srl_pkg::PhHigh: begin
                    tick_timer_next = timer_dec;
                    if (wait_done) begin
                        // hit count saturates, an inactive limit clears it
                        if (limit) begin
                            if (hit_count_reg != 16'hFFFF) begin
                                hit_count_next = hit_count_reg + 16'd1;
                            end
                        end else begin
                            hit_count_next = '0;
                        end
                        // ramp: one tick off the half-period every ramp_every steps, down to min_half_period
                        if (ramp_sum >= {1'b0, cfg.ramp_every}) begin
                            ramp_count_next = '0;
                            if (half_ext > min_ext) begin
                                half_period_next = half_period_reg - TIMER_WIDTH'(1);
                            end
                        end else begin
                            ramp_count_next = ramp_sum[7:0];
                        end
                        if (hit_count_next >= cfg.arrive_steps) begin
                            enable_next = 1'b0;
                            phase_next  = srl_pkg::PhIdle;
                            sval        = 1'b1;
                            stat        = srl_pkg::StatArrived;
                        end else begin
                            phase_next      = srl_pkg::PhLow;
                            tick_timer_next = half_period_next;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result for this item
    assign res.step_pin     = (phase_next != srl_pkg::PhLow);
    assign res.dir_pin      = move_dir_next;
    assign res.enable_pin   = enable_next;
    assign res.busy_res     = (phase_next != srl_pkg::PhIdle);
    assign res.status_valid = sval;
    assign res.status       = stat;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= srl_pkg::PhIdle;
            tick_timer_reg  <= '0;
            half_period_reg <= '0;
            hit_count_reg   <= '0;
            ramp_count_reg  <= '0;
            move_dir_reg    <= 1'b1;
            enable_reg      <= 1'b0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            tick_timer_reg  <= tick_timer_next;
            half_period_reg <= half_period_next;
            hit_count_reg   <= hit_count_next;
            ramp_count_reg  <= ramp_count_next;
            move_dir_reg    <= move_dir_next;
            enable_reg      <= enable_next;
        end
    end

    // checks
    `SRL_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> phase_reg == srl_pkg::PhIdle)
    `SRL_ASSERT(a_step_enabled, aclk, aresetn, (phase_reg == srl_pkg::PhLow || phase_reg == srl_pkg::PhHigh) |-> enable_reg)
    `SRL_ASSERT(a_hold_state, aclk, aresetn, (aresetn && !advance) |=> ($stable(phase_reg) && $stable(tick_timer_reg) && $stable(hit_count_reg)))
    `SRL_ASSERT(a_done_idle, aclk, aresetn, (advance && res.status_valid) |=> phase_reg == srl_pkg::PhIdle)

endmodule

FILE: rtl/core/stepper_ramp_to_limit_top.sv
// channel  | handshake          | payload
// s_       | s_valid / s_ready  | s_command s_direction s_back_limit s_out_limit
// m_       | m_valid / m_ready  | m_step_pin m_dir_pin m_enable_pin m_busy_res
//          |                    | m_status_valid m_status
// apb      | psel penable pready| paddr pwdata pwrite prdata
//
// one item per clock while m_ready is high; the result register loads when the held item advances
// the pace is set by the single state update per item between input and result registers
// aresetn is synchronous, active low, and clears the move state, valid flags and config registers
// while m_ready is low the result holds and one further item waits in the input register
module stepper_ramp_to_limit_top #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic                          s_direction,
    input  logic                          s_back_limit,
    input  logic                          s_out_limit,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_step_pin,
    output logic                          m_dir_pin,
    output logic                          m_enable_pin,
    output logic                          m_busy_res,
    output logic                          m_status_valid,
    output logic                          m_status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srl_pkg::AddrWidth-1:0] paddr,
    input  logic [srl_pkg::DataWidth-1:0] pwdata,
    output logic [srl_pkg::DataWidth-1:0] prdata,
    output logic                          pready
);

    srl_pkg::item_t item_reg;
    logic           in_valid_reg;
    srl_pkg::res_t  res_reg, res_comb;
    logic           out_valid_reg;
    srl_pkg::cfg_t  cfg;
    logic           advance;

    // an item moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command    <= s_command;
            item_reg.direction  <= s_direction;
            item_reg.back_limit <= s_back_limit;
            item_reg.out_limit  <= s_out_limit;
        end
    end

    srl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srl_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res_comb)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_step_pin     = res_reg.step_pin;
    assign m_dir_pin      = res_reg.dir_pin;
    assign m_enable_pin   = res_reg.enable_pin;
    assign m_busy_res     = res_reg.busy_res;
    assign m_status_valid = res_reg.status_valid;
    assign m_status       = res_reg.status;

endmodule
